@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/mcp_pkg.sv @@
// ============================================================================
// mcp_pkg: shared constants for the class period unit
// Field widths and the reset value of the size register.
// ============================================================================
`timescale 1ns / 1ps

package mcp_pkg;

    localparam int ROW_MASK_W = 16;
    localparam int SIZE_W     = 5;
    localparam int PERIOD_W   = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

endpackage

@@ rtl/markov_class_period_unit.sv @@
// ============================================================================
// markov_class_period_unit: period of one Markov chain class (boolean powers)
// Row requests leave the unit ready for the next row and produce no result.
// Last row: n+2 boolean products on the adjacency RAM read port, n+3 checks, and a gcd
//   fold at each exponent k>0 whose power has a set diagonal bit, then one result.
// Reset: async active low; clears control, result valid, sets size_reg to 16.
// ============================================================================
`timescale 1ns / 1ps

module markov_class_period_unit #(
    parameter int MAX_STATES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mcp_pkg::SIZE_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mcp_pkg::ROW_MASK_W-1:0] row_mask,
    input  logic                           last_row,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mcp_pkg::PERIOD_W-1:0]   period
);

    import mcp_pkg::*;

    localparam int IDX_W = $clog2(MAX_STATES);
    localparam int CNT_W = $clog2(MAX_STATES + 1);
    localparam int K_W   = $clog2(MAX_STATES + 3);
    localparam int SW    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int XW    = (ROW_MASK_W > MAX_STATES) ? ROW_MASK_W : MAX_STATES;
    localparam int PW    = (K_W > PERIOD_W) ? K_W : PERIOD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SWEEP,
        S_GCD,
        S_DONE
    } state_t;

    typedef logic [MAX_STATES-1:0] row_t;

    state_t                state_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [CNT_W-1:0]      rows_loaded_reg;
    logic [K_W-1:0]        k_reg;
    logic [CNT_W-1:0]      j_reg;
    logic                  rdv_reg;
    logic [IDX_W-1:0]      jd_reg;
    logic [K_W-1:0]        gcd_reg;
    logic                  out_valid_reg;
    logic [PERIOD_W-1:0]   period_reg;

    row_t                  adj_mem [MAX_STATES];
    row_t                  rdata_reg;
    row_t                  p_reg [MAX_STATES];
    row_t                  acc_reg [MAX_STATES];
    row_t                  acc_next [MAX_STATES];
    logic [K_W-1:0]        ga_reg;
    logic [K_W-1:0]        gb_reg;

    logic                  in_fire;
    logic [SW-1:0]         size_w;
    logic [CNT_W-1:0]      n_eff;
    logic [CNT_W-1:0]      n_m1;
    row_t                  keep;
    logic [XW-1:0]         row_x;
    row_t                  wr_row;
    logic                  wr_en;
    logic                  rd_en;
    logic                  hit;
    logic                  sweep_last;
    logic                  k_last;
    logic [PW-1:0]         gcd_x;
    logic                  emit;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign period    = period_reg;

    // Clamp the configured size into 1..MAX_STATES.
    always_comb
    begin
        size_w = SW'(size_reg);
        if (size_w == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (size_w > SW'(MAX_STATES))
        begin
            n_eff = CNT_W'(MAX_STATES);
        end
        else
        begin
            n_eff = CNT_W'(size_w);
        end
    end

    assign n_m1 = n_eff - CNT_W'(1);

    always_comb
    begin
        for (int b = 0; b < MAX_STATES; b++)
        begin
            keep[b] = (CNT_W'(b) < n_eff);
        end
    end

    assign row_x  = XW'(row_mask);
    assign wr_row = row_x[MAX_STATES-1:0];
    assign wr_en  = in_fire && (rows_loaded_reg < CNT_W'(MAX_STATES));
    assign rd_en  = (state_reg == S_SWEEP) && (j_reg < n_eff);

    // Rows at or above n stay zero, so the whole diagonal can be scanned.
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < MAX_STATES; i++)
        begin
            hit = hit | p_reg[i][i];
        end
    end

    // Fold adjacency row jd into every power row that reaches state jd.
    always_comb
    begin
        for (int i = 0; i < MAX_STATES; i++)
        begin
            acc_next[i] = acc_reg[i];
            if (rdv_reg && p_reg[i][jd_reg])
            begin
                acc_next[i] = acc_reg[i] | (rdata_reg & keep);
            end
        end
    end

    assign sweep_last = rdv_reg && (jd_reg == n_m1[IDX_W-1:0]);
    assign k_last     = (k_reg == (K_W'(n_eff) + K_W'(2)));
    assign gcd_x      = PW'(gcd_reg);
    assign emit       = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Adjacency RAM: one write port for loading, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            adj_mem[rows_loaded_reg[IDX_W-1:0]] <= wr_row;
        end
        if (rd_en)
        begin
            rdata_reg <= adj_mem[j_reg[IDX_W-1:0]];
        end
    end

    // Work rows and gcd operands.
    always_ff @(posedge clk)
    begin
        if (in_fire && last_row)
        begin
            // Start from the identity so the first sweep yields A itself.
            for (int i = 0; i < MAX_STATES; i++)
            begin
                p_reg[i] <= (CNT_W'(i) < n_eff) ? (row_t'(1) << i) : '0;
            end
        end
        else if (state_reg == S_SWEEP)
        begin
            for (int i = 0; i < MAX_STATES; i++)
            begin
                acc_reg[i] <= acc_next[i];
                if (sweep_last)
                begin
                    p_reg[i] <= acc_next[i];
                end
            end
        end
        else
        begin
            for (int i = 0; i < MAX_STATES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end

        if (state_reg == S_CHECK)
        begin
            ga_reg <= gcd_reg;
            gb_reg <= k_reg;
        end
        else if ((state_reg == S_GCD) && (gb_reg != '0))
        begin
            if (ga_reg >= gb_reg)
            begin
                ga_reg <= ga_reg - gb_reg;
            end
            else
            begin
                ga_reg <= gb_reg;
                gb_reg <= ga_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            size_reg        <= SIZE_RESET;
            rows_loaded_reg <= '0;
            k_reg           <= '0;
            j_reg           <= '0;
            rdv_reg         <= 1'b0;
            jd_reg          <= '0;
            gcd_reg         <= '0;
            out_valid_reg   <= 1'b0;
            period_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            rdv_reg <= rd_en;
            if (rd_en)
            begin
                jd_reg <= j_reg[IDX_W-1:0];
                j_reg  <= j_reg + CNT_W'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (last_row)
                        begin
                            rows_loaded_reg <= '0;
                            k_reg           <= '0;
                            gcd_reg         <= '0;
                            state_reg       <= S_CHECK;
                        end
                        else if (wr_en)
                        begin
                            rows_loaded_reg <= rows_loaded_reg + CNT_W'(1);
                        end
                    end
                end
                S_CHECK:
                begin
                    if ((k_reg != '0) && hit)
                    begin
                        state_reg <= S_GCD;
                    end
                    else if (k_last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        state_reg <= S_SWEEP;
                    end
                end
                S_GCD:
                begin
                    if (gb_reg == '0)
                    begin
                        gcd_reg <= ga_reg;
                        if (k_last)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            j_reg     <= '0;
                            state_reg <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP:
                begin
                    if (sweep_last)
                    begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= S_CHECK;
                    end
                end
                S_DONE:
                begin
                    // Hold the result until the output register is free.
                    if (emit)
                    begin
                        period_reg <= gcd_x[PERIOD_W-1:0];
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/mcp_checker.sv @@
// ============================================================================
// mcp_checker: port-level checks for the class period unit
// Watches the request and result handshakes over time.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         last_row,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [mcp_pkg::PERIOD_W-1:0] period
);

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(period))

    // A final row starts the computation and blocks further requests.
    `ASSERT_NEXT(a_last_busy, clk, rst_n, in_valid && in_ready && last_row, !in_ready)

    // Ordinary rows keep the block ready.
    `ASSERT_NEXT(a_row_ready, clk, rst_n, in_valid && in_ready && !last_row, in_ready)

    // A new result only comes out of a busy period.
    `ASSERT_NOW(a_result_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind markov_class_period_unit mcp_checker u_mcp_checker (.*);
